[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by text_string_width_core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[sv/tsw_pkg.sv]
// ----------------------------------------------------------------------------
// tsw_pkg
// shared types and constants of the text string width block
// ----------------------------------------------------------------------------
package tsw_pkg;

  // default number of glyphs in the offset table
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  localparam int unsigned OFFSET_W    = 16;
  localparam int unsigned WIDTH_W     = 15;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = 15'h7fff;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = 16'hffff;
  localparam logic [15:0]         DOUBLE_INC = 16'hffff;
  localparam logic [31:0]         DDA_HALF   = 32'h0000_7fff;

  // effects register bits
  localparam int unsigned EFF_THICKEN = 0;
  localparam int unsigned EFF_SKEW    = 1;
  localparam int unsigned EFF_OUTLINE = 2;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_MEASURE = 1'b1
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIRST_CHAR     = 3'd0,
    REG_MONOSPACE      = 3'd1,
    REG_EFFECTS        = 3'd2,
    REG_SCALED         = 3'd3,
    REG_DDA_INCREMENT  = 3'd4,
    REG_SCALE_UP       = 3'd5,
    REG_THICKEN_PIXELS = 3'd6,
    REG_SKEW_EXTRA     = 3'd7
  } cfg_reg_t;

endpackage

[sv/tsw_offset_mem.sv]
// ----------------------------------------------------------------------------
// tsw_offset_mem
// glyph offset table: one write port, two registered read ports
// ----------------------------------------------------------------------------
module tsw_offset_mem #(
  parameter int unsigned TABLE_DEPTH = tsw_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ADDR_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [tsw_pkg::OFFSET_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr_lo,
  input  logic [ADDR_W-1:0]             rd_addr_hi,
  output logic [tsw_pkg::OFFSET_W-1:0]  rd_data_lo,
  output logic [tsw_pkg::OFFSET_W-1:0]  rd_data_hi
);

  // one entry past the last glyph closes the last width
  logic [tsw_pkg::OFFSET_W-1:0] mem [TABLE_DEPTH + 1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_lo <= mem[rd_addr_lo];
      rd_data_hi <= mem[rd_addr_hi];
    end
  end

endmodule

[sv/text_string_width_core.sv]
// ----------------------------------------------------------------------------
// text_string_width_core
// pixel width of a text string in a bitmap font
// ----------------------------------------------------------------------------
// Load words (kind 0) write one entry of the glyph offset table; measure words
// (kind 1) each add one glyph width to a running sum, and the word with last
// set closes the string and yields one result word with the scaled, decorated
// width and the character count. The block takes one word per clock cycle,
// loads and characters alike, with no gaps between strings, unless a stalled
// receiver backs it up through in_stall. After the last character is taken,
// its string is registered through the offset table read, the running sum,
// the scaling and thicken multipliers, the sizer, and the final add of the
// effect extras into the output register. The rate is set by the running sum,
// which closes combinationally in stage a, and by the two read ports of the
// offset table, which deliver both neighbouring offsets of a glyph at once. A load is
// seen by a character taken in the very next cycle. Table entries hold no reset
// value; read only entries that have been loaded. Configuration is to be written through
// the plain write port while no string is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_string_width_core #(
  parameter int unsigned TABLE_DEPTH = tsw_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [tsw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tsw_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input words
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [8:0]                        entry_index,
  input  logic [15:0]                       entry_value,
  input  logic [7:0]                        char_code,
  input  logic                              last,
  // result words
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tsw_pkg::WIDTH_W-1:0]       text_width,
  output logic [tsw_pkg::COUNT_W-1:0]       char_count
);

  localparam int unsigned ADDR_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned GLYPH_W = $clog2(TABLE_DEPTH);
  localparam int unsigned WW      = tsw_pkg::WIDTH_W;
  localparam int unsigned CW      = tsw_pkg::COUNT_W;

  // configuration registers
  logic [7:0]  first_char;
  logic        monospace;
  logic [2:0]  effects;
  logic        scaled;
  logic [15:0] dda_increment;
  logic        scale_up;
  logic [7:0]  thicken_pixels;
  logic [8:0]  skew_extra;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_char     <= '0;
      monospace      <= 1'b0;
      effects        <= '0;
      scaled         <= 1'b0;
      dda_increment  <= '0;
      scale_up       <= 1'b0;
      thicken_pixels <= '0;
      skew_extra     <= '0;
    end else if (cfg_write) begin
      unique case (tsw_pkg::cfg_reg_t'(cfg_index))
        tsw_pkg::REG_FIRST_CHAR:     first_char     <= cfg_data[7:0];
        tsw_pkg::REG_MONOSPACE:      monospace      <= cfg_data[0];
        tsw_pkg::REG_EFFECTS:        effects        <= cfg_data[2:0];
        tsw_pkg::REG_SCALED:         scaled         <= cfg_data[0];
        tsw_pkg::REG_DDA_INCREMENT:  dda_increment  <= cfg_data;
        tsw_pkg::REG_SCALE_UP:       scale_up       <= cfg_data[0];
        tsw_pkg::REG_THICKEN_PIXELS: thicken_pixels <= cfg_data[7:0];
        tsw_pkg::REG_SKEW_EXTRA:     skew_extra     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy; a stage takes a new word when it is empty or drains
  logic a_valid, b_valid, c_valid, d_valid;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  assign rdy_e = !out_valid || !out_stall;
  assign rdy_d = !d_valid || rdy_e;
  assign rdy_c = !c_valid || rdy_d;
  assign rdy_b = !b_valid || rdy_c;
  assign rdy_a = !a_valid || rdy_b;

  assign in_stall = !rdy_a;

  logic accept, is_load, is_measure;
  assign accept     = in_valid && !in_stall;
  assign is_load    = accept && (tsw_pkg::kind_t'(kind) == tsw_pkg::KIND_LOAD);
  assign is_measure = accept && (tsw_pkg::kind_t'(kind) == tsw_pkg::KIND_MEASURE);

  // glyph index: (char_code - first_char) mod TABLE_DEPTH by restoring steps
  logic [7:0]         code_rem, first_rem;
  logic [GLYPH_W-1:0] code_mod, first_mod, glyph_idx;
  logic [GLYPH_W:0]   idx_wrap;

  always_comb begin
    code_rem  = char_code;
    first_rem = first_char;
    for (int k = 7; k >= 0; k--) begin
      if (32'(code_rem) >= (TABLE_DEPTH << k)) begin
        code_rem = code_rem - 8'(TABLE_DEPTH << k);
      end
      if (32'(first_rem) >= (TABLE_DEPTH << k)) begin
        first_rem = first_rem - 8'(TABLE_DEPTH << k);
      end
    end
    code_mod  = GLYPH_W'(code_rem);
    first_mod = GLYPH_W'(first_rem);
    if (code_mod >= first_mod) begin
      idx_wrap = (GLYPH_W+1)'(code_mod) - (GLYPH_W+1)'(first_mod);
    end else begin
      idx_wrap = (GLYPH_W+1)'(code_mod) + (GLYPH_W+1)'(TABLE_DEPTH)
               - (GLYPH_W+1)'(first_mod);
    end
    // every glyph of a monospaced font is glyph zero
    glyph_idx = monospace ? '0 : idx_wrap[GLYPH_W-1:0];
  end

  logic [ADDR_W-1:0] rd_addr_lo, rd_addr_hi;
  assign rd_addr_lo = ADDR_W'(glyph_idx);
  assign rd_addr_hi = rd_addr_lo + ADDR_W'(1);

  // loads past the closing entry are dropped
  logic load_ok;
  assign load_ok = is_load && (32'(entry_index) <= TABLE_DEPTH);

  logic [tsw_pkg::OFFSET_W-1:0] off_lo, off_hi;

  tsw_offset_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_offset_mem (
    .clk        (clk),
    .wr_en      (load_ok),
    .wr_addr    (ADDR_W'(entry_index)),
    .wr_data    (entry_value),
    .rd_en      (is_measure),
    .rd_addr_lo (rd_addr_lo),
    .rd_addr_hi (rd_addr_hi),
    .rd_data_lo (off_lo),
    .rd_data_hi (off_hi)
  );

  // stage a: offsets arrive from the table; running sum closes here
  logic          a_last;
  logic [WW-1:0] acc_width;
  logic [CW-1:0] acc_count;
  logic          a_move;
  logic [15:0]   glyph_w;
  logic [16:0]   sum_w;
  logic [WW-1:0] width_next;
  logic [CW-1:0] count_next;

  assign a_move  = a_valid && rdy_b;
  assign glyph_w = off_hi - off_lo;
  assign sum_w   = 17'(acc_width) + 17'(glyph_w);

  always_comb begin
    width_next = (sum_w > 17'(tsw_pkg::WIDTH_MAX)) ? tsw_pkg::WIDTH_MAX : sum_w[WW-1:0];
    count_next = (acc_count == tsw_pkg::COUNT_MAX) ? acc_count : acc_count + CW'(1);
  end

  // stage b: string totals; stage c: products; stage d: sized width
  logic [WW-1:0] b_width, c_width, d_width;
  logic [CW-1:0] b_count, c_count, d_count;
  logic [30:0]   c_dda;
  logic [23:0]   c_thk, d_thk;

  // sizer on the registered product
  logic [31:0]   dda_sum;
  logic [16:0]   dda_r;
  logic [15:0]   dbl_w;
  logic [WW-1:0] sized_w;

  always_comb begin
    dda_sum = tsw_pkg::DDA_HALF + 32'(c_dda);
    dda_r   = 17'(dda_sum[31:16]) + (scale_up ? 17'(c_width) : 17'd0);
    if (c_width != '0 && dda_r == '0) begin
      dda_r = 17'd1;
    end
    dbl_w = {c_width, 1'b0};
    if (!scaled) begin
      sized_w = c_width;
    end else if (dda_increment == tsw_pkg::DOUBLE_INC) begin
      sized_w = (dbl_w > 16'(tsw_pkg::WIDTH_MAX)) ? tsw_pkg::WIDTH_MAX : dbl_w[WW-1:0];
    end else begin
      sized_w = (dda_r > 17'(tsw_pkg::WIDTH_MAX)) ? tsw_pkg::WIDTH_MAX : dda_r[WW-1:0];
    end
  end

  // effect extras; all terms are non-negative so one clamp at the end is enough
  logic [25:0] total_w;

  always_comb begin
    total_w = 26'(d_width);
    if (effects[tsw_pkg::EFF_THICKEN] && !monospace) begin
      total_w = total_w + 26'(d_thk);
    end
    if (effects[tsw_pkg::EFF_SKEW]) begin
      total_w = total_w + 26'(skew_extra);
    end
    if (effects[tsw_pkg::EFF_OUTLINE]) begin
      total_w = total_w + 26'({d_count, 1'b0});
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
      acc_width <= '0;
      acc_count <= '0;
    end else begin
      if (rdy_a) begin
        a_valid <= is_measure;
      end
      if (a_move) begin
        acc_width <= a_last ? '0 : width_next;
        acc_count <= a_last ? '0 : count_next;
      end
      if (rdy_b) begin
        b_valid <= a_valid && a_last;
      end
      if (rdy_c) begin
        c_valid <= b_valid;
      end
      if (rdy_d) begin
        d_valid <= c_valid;
      end
      if (rdy_e) begin
        out_valid <= d_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (is_measure) begin
      a_last <= last;
    end
    if (rdy_b) begin
      b_width <= width_next;
      b_count <= count_next;
    end
    if (rdy_c) begin
      c_width <= b_width;
      c_count <= b_count;
      c_dda   <= b_width * dda_increment;
      c_thk   <= b_count * thicken_pixels;
    end
    if (rdy_d) begin
      d_width <= sized_w;
      d_count <= c_count;
      d_thk   <= c_thk;
    end
    if (rdy_e) begin
      text_width <= (total_w > 26'(tsw_pkg::WIDTH_MAX)) ? tsw_pkg::WIDTH_MAX
                                                        : total_w[WW-1:0];
      char_count <= d_count;
    end
  end

  // a string always holds at least one character
  `ASSERT_NEVER(a_count_nonzero, clk, rst, out_valid && char_count == '0, "zero char count")

  // the running sums start over after the last character leaves stage a
  `ASSERT_CLK(a_acc_clear, clk, rst, (a_move && a_last) |=> (acc_width == '0 && acc_count == '0), "running sums not cleared")

  // input backs up only while the table read stage and the string totals stage are both occupied
  `ASSERT_CLK(a_stall_full, clk, rst, in_stall |-> (a_valid && b_valid), "stall with free stages")

endmodule

[tb/text_string_width_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_string_width_checker
// watches the word channels of the string width block and checks its results
// ----------------------------------------------------------------------------
// Mirrors the configuration writes and the offset table loads, predicts the
// width and character count of every closed string, and compares each result
// word in order against the oldest prediction.
// ----------------------------------------------------------------------------
module text_string_width_checker
  import tsw_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   kind,
  input  logic [8:0]             entry_index,
  input  logic [15:0]            entry_value,
  input  logic [7:0]             char_code,
  input  logic                   last,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [WIDTH_W-1:0]     text_width,
  input  logic [COUNT_W-1:0]     char_count,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen
);

  typedef struct {
    logic [WIDTH_W-1:0] width;
    logic [COUNT_W-1:0] count;
  } string_result_t;

  string_result_t expected_widths[$];

  logic [OFFSET_W-1:0] glyph_offset [0:TABLE_DEPTH];
  int unsigned         width_sum;
  int unsigned         char_total;

  logic [7:0]  base_code;
  logic        mono_font;
  logic [2:0]  fx_bits;
  logic        scaled_font;
  logic [15:0] dda_step;
  logic        enlarge;
  logic [7:0]  thick_px;
  logic [8:0]  skew_px;

  int errors = 0;
  int seen   = 0;

  function automatic int unsigned clip_width(input longint unsigned v);
    return (v > WIDTH_MAX) ? WIDTH_MAX : v[31:0];
  endfunction

  // wrapped difference of neighbouring offsets
  function automatic int unsigned glyph_span(input logic [7:0] code);
    int unsigned slot;
    logic [15:0] span;
    if (mono_font) begin
      slot = 0;
    end else begin
      slot = (32'(code) + 256 * TABLE_DEPTH - 32'(base_code)) % TABLE_DEPTH;
    end
    span = glyph_offset[slot + 1] - glyph_offset[slot];
    return span;
  endfunction

  // dda sizer in closed form
  function automatic int unsigned sized_width(input int unsigned n);
    longint unsigned r;
    if (dda_step == DOUBLE_INC) begin
      return clip_width(64'(n) * 2);
    end
    r = (64'(DDA_HALF) + 64'(n) * dda_step) >> 16;
    if (enlarge) r += n;
    if (n != 0 && r == 0) r = 1;
    return clip_width(r);
  endfunction

  function automatic string_result_t close_string();
    int unsigned w;
    string_result_t res;
    w = width_sum;
    if (scaled_font) w = sized_width(w);
    if (fx_bits[EFF_THICKEN] && !mono_font) w = clip_width(64'(w) + 64'(char_total) * thick_px);
    if (fx_bits[EFF_SKEW]) w = clip_width(64'(w) + skew_px);
    if (fx_bits[EFF_OUTLINE]) w = clip_width(64'(w) + 64'(char_total) * 2);
    res.width = w[WIDTH_W-1:0];
    res.count = char_total[COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : track
    string_result_t want;
    if (rst) begin
      base_code   = '0;
      mono_font   = 1'b0;
      fx_bits     = '0;
      scaled_font = 1'b0;
      dda_step    = '0;
      enlarge     = 1'b0;
      thick_px    = '0;
      skew_px     = '0;
      width_sum   = 0;
      char_total  = 0;
      expected_widths.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen++;
        if (expected_widths.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result word: width %0d count %0d",
                     $time, text_width, char_count);
          end
        end else begin
          want = expected_widths.pop_front();
          if (text_width !== want.width || char_count !== want.count) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result mismatch: width %0d (expected %0d) count %0d (expected %0d)",
                       $time, text_width, want.width, char_count, want.count);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (kind == KIND_LOAD) begin
          if (entry_index <= TABLE_DEPTH) glyph_offset[entry_index] = entry_value;
        end else begin
          width_sum = clip_width(64'(width_sum) + glyph_span(char_code));
          if (char_total < COUNT_MAX) char_total++;
          if (last) begin
            expected_widths.push_back(close_string());
            width_sum  = 0;
            char_total = 0;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_FIRST_CHAR:     base_code   = cfg_data[7:0];
          REG_MONOSPACE:      mono_font   = cfg_data[0];
          REG_EFFECTS:        fx_bits     = cfg_data[2:0];
          REG_SCALED:         scaled_font = cfg_data[0];
          REG_DDA_INCREMENT:  dda_step    = cfg_data[15:0];
          REG_SCALE_UP:       enlarge     = cfg_data[0];
          REG_THICKEN_PIXELS: thick_px    = cfg_data[7:0];
          REG_SKEW_EXTRA:     skew_px     = cfg_data[8:0];
          default: ;
        endcase
      end
    end
    fail_count   <= errors;
    pending      <= expected_widths.size();
    results_seen <= seen;
  end

endmodule

[tb/text_string_width_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_string_width_core_tb
// stimulus and verdict for the text string width block
// ----------------------------------------------------------------------------
// Fills the glyph offset table, runs a short directed set of strings around
// the corner cases, then random strings mixed with table reloads under three
// idle patterns and a long receiver hold-off. Results are checked by the
// companion checker module.
// ----------------------------------------------------------------------------
module text_string_width_core_tb;
  import tsw_pkg::*;

  localparam int TABLE_DEPTH     = TABLE_DEPTH_DEF;
  localparam int WORDS_PER_PHASE = 370;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 12;  // margin for the pipeline to drain
  localparam int QUIET_LIMIT     = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // configuration port
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // input words
  logic       in_valid    = 1'b0;
  logic       in_stall;
  kind_t      kind        = KIND_LOAD;
  logic [8:0] entry_index = '0;
  logic [15:0] entry_value = '0;
  logic [7:0] char_code   = '0;
  logic       last        = 1'b0;

  // result words
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [WIDTH_W-1:0] text_width;
  logic [COUNT_W-1:0] char_count;

  int fail_count;
  int pending;
  int results_seen;

  // idle percentages, changed per phase
  int snd_idle_pct = 18;
  int rcv_idle_pct = 52;
  // bumped by the stimulus each time it wants a long hold-off
  int hold_req     = 0;

  int words_sent   = 0;
  int strings_sent = 0;
  int quiet        = 0;

  // stimulus-side copy of the table, only used to make plausible offsets
  logic [15:0] font_off [0:TABLE_DEPTH];

  always #5 clk = ~clk;

  text_string_width_core #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .char_code   (char_code),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .text_width  (text_width),
    .char_count  (char_count)
  );

  text_string_width_checker #(.TABLE_DEPTH(TABLE_DEPTH)) width_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .char_code    (char_code),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .text_width   (text_width),
    .char_count   (char_count),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // receiver: random stalls, or one long hold-off when asked
  initial begin : receiver
    int n;
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req != holds_done) begin
        holds_done = hold_req;
        out_stall <= 1'b1;
        for (n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  // watchdog: ends the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one word on the input channel, with random idle cycles ahead of it
  task automatic put_word(input kind_t k, input logic [8:0] idx, input logic [15:0] val,
                          input logic [7:0] code, input logic fin);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    entry_index <= idx;
    entry_value <= val;
    char_code   <= code;
    last        <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // load word; unused fields carry noise
  task automatic load_entry(input int idx, input logic [15:0] val);
    put_word(KIND_LOAD, idx[8:0], val, 8'($urandom()), 1'($urandom()));
    if (idx <= TABLE_DEPTH) font_off[idx] = val;
  endtask

  task automatic put_char(input logic [7:0] code, input logic fin);
    put_word(KIND_MEASURE, 9'($urandom()), 16'($urandom()), code, fin);
    if (fin) strings_sent++;
  endtask

  // drop valid and wait until every result is back and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all eight registers on back-to-back cycles; noise above each field narrower than the data word
  task automatic program_font(input logic [7:0] fc, input logic mono, input logic [2:0] fx,
                              input logic sc, input logic [15:0] dda, input logic up,
                              input logic [7:0] thick, input logic [8:0] skew);
    logic [15:0] v [0:7];
    cfg_reg_t r;
    v[REG_FIRST_CHAR]     = {8'($urandom()), fc};
    v[REG_MONOSPACE]      = {15'($urandom()), mono};
    v[REG_EFFECTS]        = {13'($urandom()), fx};
    v[REG_SCALED]         = {15'($urandom()), sc};
    v[REG_DDA_INCREMENT]  = dda;
    v[REG_SCALE_UP]       = {15'($urandom()), up};
    v[REG_THICKEN_PIXELS] = {8'($urandom()), thick};
    v[REG_SKEW_EXTRA]     = {7'($urandom()), skew};
    r = REG_FIRST_CHAR;
    repeat (8) begin
      cfg_write <= 1'b1;
      cfg_index <= r;
      cfg_data  <= v[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_write <= 1'b0;
  endtask

  // zero, top of range, or anything in between
  function automatic logic [15:0] pick(input logic [15:0] hi);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return hi;
      default: return 16'($urandom_range(0, hi));
    endcase
  endfunction

  task automatic random_font();
    program_font(8'(pick(16'hff)), 1'(pick(16'd1)), 3'(pick(16'd7)), 1'(pick(16'd1)),
                 pick(16'hffff), 1'(pick(16'd1)), 8'(pick(16'hff)), 9'(pick(16'h1ff)));
  endtask

  // mostly near the previous offset so widths stay small, some raw noise,
  // and now and then an index beyond the table
  task automatic random_load();
    int idx;
    logic [15:0] val;
    if ($urandom_range(0, 9) == 0) begin
      idx = $urandom_range(TABLE_DEPTH + 1, 511);
    end else begin
      idx = $urandom_range(0, TABLE_DEPTH);
    end
    if (idx == 0 || idx > TABLE_DEPTH || $urandom_range(0, 4) == 0) begin
      val = 16'($urandom());
    end else begin
      val = font_off[idx - 1] + 16'($urandom_range(0, 24));
    end
    load_entry(idx, val);
  endtask

  // random strings, an occasional reload between or inside them,
  // and a fresh register setting now and then at a string boundary
  task automatic run_phase(input int words);
    int done;
    int len;
    done = 0;
    while (done < words) begin
      if ($urandom_range(0, 99) < 8) begin
        settle();
        random_font();
      end
      if ($urandom_range(0, 99) < 15) begin
        random_load();
        done++;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 5) begin
          random_load();
          done++;
        end
        put_char(8'($urandom()), i == len - 1);
      end
      done += len;
    end
    settle();
  endtask

  initial begin : stimulus
    logic [15:0] offset_acc;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    program_font(8'd0, 1'b0, 3'd0, 1'b0, 16'h0000, 1'b0, 8'd0, 9'd0);

    // whole table first, so no character ever reads an empty entry
    offset_acc = 16'($urandom());
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      load_entry(i, offset_acc);
      offset_acc += 16'($urandom_range(0, 24));
    end

    // single characters at both ends of the code range
    put_char(8'd0, 1'b1);
    put_char(8'd255, 1'b1);
    // top entry reloaded in the middle of a string, seen by the next word
    put_char(8'd255, 1'b0);
    load_entry(TABLE_DEPTH, font_off[TABLE_DEPTH - 1] + 16'd7);
    put_char(8'd255, 1'b1);
    // loads past the end of the table leave it alone
    load_entry(TABLE_DEPTH + 1, 16'hffff);
    load_entry(511, 16'h0000);
    put_char(8'd255, 1'b1);
    // falling offsets give a huge wrapped width that saturates
    load_entry(10, 16'd100);
    load_entry(11, 16'd50);
    put_char(8'd10, 1'b0);
    put_char(8'd1, 1'b1);
    // equal neighbours make a zero-width glyph
    load_entry(20, 16'h8000);
    load_entry(21, 16'h8000);
    settle();

    // every register at its top value: monospace, exact double, all effects
    program_font(8'd255, 1'b1, 3'd7, 1'b1, 16'hffff, 1'b1, 8'd255, 9'd511);
    put_char(8'd0, 1'b0);
    put_char(8'd255, 1'b1);
    settle();

    // smallest shrink step: zero stays zero, anything else rounds up to one
    program_font(8'd0, 1'b0, 3'd0, 1'b1, 16'h0000, 1'b0, 8'd0, 9'd0);
    put_char(8'd20, 1'b1);
    put_char(8'd20, 1'b0);
    put_char(8'd0, 1'b1);
    settle();

    // code below the first glyph wraps around; thicken and outline on
    program_font(8'd200, 1'b0, 3'd5, 1'b1, 16'h8000, 1'b1, 8'd3, 9'd17);
    put_char(8'd5, 1'b0);
    put_char(8'd199, 1'b1);
    settle();

    // random part, sender lightly idle, receiver heavily stalled
    random_font();
    run_phase(WORDS_PER_PHASE);

    // and the other way round
    snd_idle_pct = 52;
    rcv_idle_pct = 18;
    run_phase(WORDS_PER_PHASE);

    // no idling at all
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_font();

    // receiver holds off while short strings keep coming, so the block backs up
    hold_req++;
    repeat (120) put_char(8'($urandom()), 1'($urandom()));
    put_char(8'($urandom()), 1'b1);
    run_phase(WORDS_PER_PHASE);

    $display("run covered %0d input words and %0d strings, %0d result words compared",
             words_sent, strings_sent, results_seen);
    $display("three idle patterns, table reloads mid-string and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
